[sv/cdsa_pkg.sv]
package cdsa_pkg;

  // Field widths
  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;

  localparam logic [YearW-1:0]  YearMax  = 14'd9999;
  localparam logic [MonthW-1:0] MonthMax = 4'd12;
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [DayW-1:0]   DayFirst = 5'd1;

  // Item kinds
  localparam logic KindSet     = 1'b0;
  localparam logic KindAdvance = 1'b1;

  // Year as four BCD digits, [3] = thousands ... [0] = units
  typedef logic [3:0][3:0] year_bcd_t;

  // Decoded word passed from front to back
  typedef struct packed {
    logic              adv;
    logic              set_ok;
    logic [YearW-1:0]  year;
    year_bcd_t         year_bcd;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } item_t;

  // Leap test on BCD digits: 100 | y when the low two digits are zero,
  // 4 | y from (2*tens + units) mod 4, 400 | y likewise on the high pair
  function automatic logic is_leap(input year_bcd_t yd);
    logic       div100;
    logic [1:0] lo4;
    logic [1:0] hi4;
    div100 = (yd[1] == 4'd0) && (yd[0] == 4'd0);
    lo4    = {yd[1][0], 1'b0} + yd[0][1:0];
    hi4    = {yd[3][0], 1'b0} + yd[2][1:0];
    return (div100 && (hi4 == 2'd0)) || (!div100 && (lo4 == 2'd0));
  endfunction

  // Days in month; zero for a month outside 1..12
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[sv/cdsa_front.sv]
module cdsa_front (
  input  logic           kind,
  input  logic [7:0]     char_0,
  input  logic [7:0]     char_1,
  input  logic [7:0]     char_2,
  input  logic [7:0]     char_3,
  input  logic [7:0]     char_4,
  input  logic [7:0]     char_5,
  input  logic [7:0]     char_6,
  input  logic [7:0]     char_7,
  output cdsa_pkg::item_t item
);

  logic [7:0][7:0] ch;
  logic [7:0][3:0] dig;
  logic [7:0]      is_dig;
  logic [6:0]      month_bin;
  logic [6:0]      day_bin;
  logic [cdsa_pkg::DayW-1:0] len;
  logic            month_ok;
  logic            day_ok;

  assign ch = {char_7, char_6, char_5, char_4, char_3, char_2, char_1, char_0};

  // ASCII digit check: high nibble 3, low nibble 0..9
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      is_dig[i] = (ch[i][7:4] == 4'h3) && (ch[i][3:0] <= 4'd9);
      dig[i]    = ch[i][3:0];
    end
  end

  // Binary month and day from two digits each
  assign month_bin = 7'(dig[4]) * 7'd10 + 7'(dig[5]);
  assign day_bin   = 7'(dig[6]) * 7'd10 + 7'(dig[7]);

  // Range checks against month length
  assign month_ok = (month_bin >= 7'd1) && (month_bin <= 7'(cdsa_pkg::MonthMax));
  assign len      = cdsa_pkg::month_len(month_bin[3:0],
                                        cdsa_pkg::is_leap({dig[0], dig[1], dig[2], dig[3]}));
  assign day_ok   = (day_bin >= 7'd1) && (day_bin <= 7'(len));

  // Pack decoded word
  always_comb begin
    item.adv      = (kind == cdsa_pkg::KindAdvance);
    item.set_ok   = (&is_dig) && month_ok && day_ok;
    item.year_bcd = {dig[0], dig[1], dig[2], dig[3]};
    item.year     = 14'(dig[0]) * 14'd1000 + 14'(dig[1]) * 14'd100
                  + 14'(dig[2]) * 14'd10 + 14'(dig[3]);
    item.month    = month_bin[3:0];
    item.day      = day_bin[4:0];
  end

endmodule

[sv/cdsa_queue.sv]
module cdsa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cdsa_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output cdsa_pkg::item_t head
);

  cdsa_pkg::item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("pop from empty queue");

endmodule

[sv/cdsa_back.sv]
module cdsa_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_not_empty,
  input  cdsa_pkg::item_t               q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          date_ok,
  output logic [cdsa_pkg::YearW-1:0]    out_year,
  output logic [cdsa_pkg::MonthW-1:0]   out_month,
  output logic [cdsa_pkg::DayW-1:0]     out_day
);

  // Stored date, binary and BCD year kept in step
  logic [cdsa_pkg::YearW-1:0]  year;
  cdsa_pkg::year_bcd_t         year_bcd;
  logic [cdsa_pkg::MonthW-1:0] month;
  logic [cdsa_pkg::DayW-1:0]   day;

  logic [cdsa_pkg::YearW-1:0]  year_next;
  cdsa_pkg::year_bcd_t         year_bcd_next;
  logic [cdsa_pkg::MonthW-1:0] month_next;
  logic [cdsa_pkg::DayW-1:0]   day_next;
  logic                        ok_next;

  logic [cdsa_pkg::DayW-1:0]   cur_len;
  cdsa_pkg::year_bcd_t         bcd_inc;
  logic                        carry;

  // Take a word when the output register is free or being drained
  assign q_pop   = q_not_empty && (!out_valid || !out_stall);
  assign cur_len = cdsa_pkg::month_len(month, cdsa_pkg::is_leap(year_bcd));

  // BCD year increment, 9999 wraps to 0000
  always_comb begin
    carry = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (carry && (year_bcd[i] == 4'd9)) begin
        bcd_inc[i] = 4'd0;
      end else begin
        bcd_inc[i] = year_bcd[i] + {3'd0, carry};
        carry      = 1'b0;
      end
    end
  end

  // Next date for set or advance
  always_comb begin
    year_next     = year;
    year_bcd_next = year_bcd;
    month_next    = month;
    day_next      = day;
    ok_next       = 1'b1;
    if (q_head.adv) begin
      if (day < cur_len) begin
        day_next = day + 5'd1;
      end else begin
        day_next = cdsa_pkg::DayFirst;
        if (month < cdsa_pkg::MonthMax) begin
          month_next = month + 4'd1;
        end else begin
          month_next    = cdsa_pkg::MonthJan;
          year_bcd_next = bcd_inc;
          year_next     = (year >= cdsa_pkg::YearMax) ? '0 : year + 14'd1;
        end
      end
    end else begin
      ok_next = q_head.set_ok;
      if (q_head.set_ok) begin
        year_next     = q_head.year;
        year_bcd_next = q_head.year_bcd;
        month_next    = q_head.month;
        day_next      = q_head.day;
      end
    end
  end

  // Date state
  always_ff @(posedge clk) begin
    if (rst) begin
      year     <= '0;
      year_bcd <= '0;
      month    <= cdsa_pkg::MonthJan;
      day      <= cdsa_pkg::DayFirst;
    end else if (q_pop) begin
      year     <= year_next;
      year_bcd <= year_bcd_next;
      month    <= month_next;
      day      <= day_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      date_ok   <= ok_next;
      out_year  <= year_next;
      out_month <= month_next;
      out_day   <= day_next;
    end
  end

  a_day_in_month: assert property (@(posedge clk) disable iff (rst)
    (day >= 5'd1) && (day <= cur_len)) else $error("stored day out of range");
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (month >= 4'd1) && (month <= cdsa_pkg::MonthMax)) else $error("stored month out of range");
  a_year_bcd_match: assert property (@(posedge clk) disable iff (rst)
    year == 14'(year_bcd[3]) * 14'd1000 + 14'(year_bcd[2]) * 14'd100
          + 14'(year_bcd[1]) * 14'd10 + 14'(year_bcd[0]))
    else $error("binary and BCD year disagree");
  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_year == year) && (out_month == month) && (out_day == day))
    else $error("result word differs from stored date");

endmodule

[sv/calendar_date_set_and_advance_top.sv]
// Gregorian date register with set and advance.
// Input channel: in_valid / in_stall carry one word of kind and eight ASCII
// characters YYYYMMDD. kind 0 sets the date if the characters form a valid
// date; kind 1 advances the stored date by one day (year 9999 wraps to 0).
// Output channel: out_valid / out_stall carry one result word per input
// word: date_ok and the stored year, month and day after that word.
// A word accepted is written into the queue; the back end then takes it from
// the queue head, updates the date and loads the output register.
// Throughput: one word per cycle while the receiver does not stall, set by
// the back end, which updates the date as it takes each word.
// The front decodes and checks the characters and writes a two-entry queue;
// the back end updates the date and loads the output register.
// When the receiver stalls, the result holds and the queue fills; in_stall
// rises once the queue holds two words.
// Reset (rst, synchronous) empties the queue, drops out_valid and sets the
// date to year 0, January 1.
module calendar_date_set_and_advance_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  char_0,
  input  logic [7:0]  char_1,
  input  logic [7:0]  char_2,
  input  logic [7:0]  char_3,
  input  logic [7:0]  char_4,
  input  logic [7:0]  char_5,
  input  logic [7:0]  char_6,
  input  logic [7:0]  char_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        date_ok,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day
);

  cdsa_pkg::item_t dec_item;
  cdsa_pkg::item_t q_head;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  logic            push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  cdsa_front u_front (
    .kind   (kind),
    .char_0 (char_0),
    .char_1 (char_1),
    .char_2 (char_2),
    .char_3 (char_3),
    .char_4 (char_4),
    .char_5 (char_5),
    .char_6 (char_6),
    .char_7 (char_7),
    .item   (dec_item)
  );

  cdsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (dec_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  cdsa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .date_ok     (date_ok),
    .out_year    (out_year),
    .out_month   (out_month),
    .out_day     (out_day)
  );

endmodule

[dv/calendar_date_checker.sv]
module calendar_date_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  char_0,
  input  logic [7:0]  char_1,
  input  logic [7:0]  char_2,
  input  logic [7:0]  char_3,
  input  logic [7:0]  char_4,
  input  logic [7:0]  char_5,
  input  logic [7:0]  char_6,
  input  logic [7:0]  char_7,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        date_ok,
  input  logic [13:0] out_year,
  input  logic [3:0]  out_month,
  input  logic [4:0]  out_day,
  output int          fail_cnt,
  output int          pending_cnt,
  output int          result_cnt,
  output int          refused_cnt,
  output int          wrap_cnt
);

  localparam logic [7:0] AsciiZero = 8'd48;
  localparam logic [7:0] AsciiNine = 8'd57;
  localparam int         ShowLimit = 10;

  typedef logic [0:7][7:0] text_t;

  typedef struct packed {
    logic                        ok;
    logic [cdsa_pkg::YearW-1:0]  year;
    logic [cdsa_pkg::MonthW-1:0] month;
    logic [cdsa_pkg::DayW-1:0]   day;
  } date_word_t;

  // Calendar state mirrored from the block
  logic [cdsa_pkg::YearW-1:0]  cal_year;
  logic [cdsa_pkg::MonthW-1:0] cal_month;
  logic [cdsa_pkg::DayW-1:0]   cal_day;

  date_word_t due_dates[$];

  // Days in month m of year y, 400/100/4 leap rule; 0 for a bad month
  function automatic int days_in(input int y, input int m);
    bit leap;
    leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Apply one input word to the mirrored date, return the expected result
  function automatic date_word_t apply_word(input logic k, input text_t t);
    date_word_t res;
    int         dig [8];
    bit         digits_ok;
    int         y;
    int         m;
    int         d;
    if (k == cdsa_pkg::KindAdvance) begin
      res.ok = 1'b1;
      if (int'(cal_day) < days_in(int'(cal_year), int'(cal_month))) begin
        cal_day = cal_day + 5'd1;
      end else begin
        cal_day = cdsa_pkg::DayFirst;
        if (cal_month < cdsa_pkg::MonthMax) begin
          cal_month = cal_month + 4'd1;
        end else begin
          cal_month = cdsa_pkg::MonthJan;
          if (cal_year >= cdsa_pkg::YearMax) begin
            cal_year = '0;
            wrap_cnt++;
          end else begin
            cal_year = cal_year + 14'd1;
          end
        end
      end
    end else begin
      digits_ok = 1'b1;
      for (int i = 0; i < 8; i++) begin
        if (t[i] < AsciiZero || t[i] > AsciiNine) digits_ok = 1'b0;
        dig[i] = int'(t[i]) - int'(AsciiZero);
      end
      y = dig[0] * 1000 + dig[1] * 100 + dig[2] * 10 + dig[3];
      m = dig[4] * 10 + dig[5];
      d = dig[6] * 10 + dig[7];
      res.ok = digits_ok && (m >= 1) && (m <= 12) && (d >= 1) && (d <= days_in(y, m));
      if (res.ok) begin
        cal_year  = cdsa_pkg::YearW'(y);
        cal_month = cdsa_pkg::MonthW'(m);
        cal_day   = cdsa_pkg::DayW'(d);
      end else begin
        refused_cnt++;
      end
    end
    res.year  = cal_year;
    res.month = cal_month;
    res.day   = cal_day;
    return res;
  endfunction

  function automatic void note_failure();
    fail_cnt++;
  endfunction

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    date_word_t want;
    if (rst) begin
      cal_year  = '0;
      cal_month = cdsa_pkg::MonthJan;
      cal_day   = cdsa_pkg::DayFirst;
      due_dates.delete();
    end else begin
      // result side first; a result never shares an edge with its own word
      if (out_valid && !out_stall) begin
        result_cnt++;
        if (due_dates.size() == 0) begin
          if (fail_cnt < ShowLimit)
            $display("[%0t] result with nothing expected: ok=%0d %0d-%0d-%0d",
                     $realtime, date_ok, out_year, out_month, out_day);
          note_failure();
        end else begin
          want = due_dates.pop_front();
          if (date_ok !== want.ok || out_year !== want.year ||
              out_month !== want.month || out_day !== want.day) begin
            if (fail_cnt < ShowLimit)
              $display("[%0t] mismatch: expected ok=%0d %0d-%0d-%0d, got ok=%0d %0d-%0d-%0d",
                       $realtime, want.ok, want.year, want.month, want.day,
                       date_ok, out_year, out_month, out_day);
            note_failure();
          end
        end
      end
      if (in_valid && !in_stall)
        due_dates.push_back(apply_word(kind, {char_0, char_1, char_2, char_3,
                                              char_4, char_5, char_6, char_7}));
    end
    pending_cnt = due_dates.size();
  end

endmodule

[dv/calendar_date_set_and_advance_top_tb.sv]
module calendar_date_set_and_advance_top_tb;

  localparam int RandWords  = 1600;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 80;
  localparam int GapPct     = 19;

  typedef logic [0:7][7:0] text_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  text_t       word_text;
  logic        out_valid;
  logic        out_stall;
  logic        date_ok;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;

  int fail_cnt;
  int pending_cnt;
  int result_cnt;
  int refused_cnt;
  int wrap_cnt;
  int advance_cnt;
  int set_cnt;
  bit gaps_on;
  bit press_go;

  calendar_date_set_and_advance_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .char_0    (word_text[0]),
    .char_1    (word_text[1]),
    .char_2    (word_text[2]),
    .char_3    (word_text[3]),
    .char_4    (word_text[4]),
    .char_5    (word_text[5]),
    .char_6    (word_text[6]),
    .char_7    (word_text[7]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .date_ok   (date_ok),
    .out_year  (out_year),
    .out_month (out_month),
    .out_day   (out_day)
  );

  calendar_date_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .char_0      (word_text[0]),
    .char_1      (word_text[1]),
    .char_2      (word_text[2]),
    .char_3      (word_text[3]),
    .char_4      (word_text[4]),
    .char_5      (word_text[5]),
    .char_6      (word_text[6]),
    .char_7      (word_text[7]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .date_ok     (date_ok),
    .out_year    (out_year),
    .out_month   (out_month),
    .out_day     (out_day),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt),
    .result_cnt  (result_cnt),
    .refused_cnt (refused_cnt),
    .wrap_cnt    (wrap_cnt)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Eight ASCII digits YYYYMMDD
  function automatic text_t date_text(input int y, input int m, input int d);
    return {8'(48 + (y / 1000) % 10), 8'(48 + (y / 100) % 10),
            8'(48 + (y / 10) % 10),   8'(48 + y % 10),
            8'(48 + (m / 10) % 10),   8'(48 + m % 10),
            8'(48 + (d / 10) % 10),   8'(48 + d % 10)};
  endfunction

  function automatic text_t noise_text();
    return {$urandom, $urandom};
  endfunction

  // Offer one word from a falling edge, hold it until taken
  task automatic send_word(input logic k, input text_t t);
    while (gaps_on && $urandom_range(99) < GapPct) begin
      in_valid  = 1'b0;
      kind      = 1'($urandom_range(1));
      word_text = noise_text();
      @(negedge clk);
    end
    in_valid  = 1'b1;
    kind      = k;
    word_text = t;
    if (k == cdsa_pkg::KindAdvance) advance_cnt++;
    else set_cnt++;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // One random word: mostly good dates and advances, some bad dates, some noise
  task automatic send_random();
    int    pick;
    int    y;
    int    m;
    int    d;
    int    pos;
    text_t t;
    logic [7:0] junk;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0:       y = 9999;
      1:       y = 100 * $urandom_range(99);
      default: y = $urandom_range(9999);
    endcase
    m = ($urandom_range(3) == 0) ? (($urandom_range(1) == 1) ? 2 : 12) : $urandom_range(12, 1);
    d = ($urandom_range(1) == 1) ? $urandom_range(28, 1) : $urandom_range(31, 28);
    if (pick < 30) begin
      send_word(cdsa_pkg::KindAdvance, noise_text());
    end else if (pick < 75) begin
      send_word(cdsa_pkg::KindSet, date_text(y, m, d));
    end else if (pick < 90) begin
      // digits that do not form a date
      case ($urandom_range(3))
        0: m = 0;
        1: m = $urandom_range(99, 13);
        2: d = 0;
        default: d = $urandom_range(99, 32);
      endcase
      send_word(cdsa_pkg::KindSet, date_text(y, m, d));
    end else if ($urandom_range(1) == 1) begin
      send_word(cdsa_pkg::KindSet, noise_text());
    end else begin
      // good date with one non-digit character
      t    = date_text(y, m, d);
      pos  = $urandom_range(7);
      junk = 8'($urandom_range(255));
      if (junk >= 8'd48 && junk <= 8'd57) junk = junk ^ 8'h80;
      t[pos] = junk;
      send_word(cdsa_pkg::KindSet, t);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when asked
  initial begin
    int  hold_left;
    bit  press_done;
    hold_left  = 0;
    press_done = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (press_go && !press_done) begin
        press_done = 1'b1;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = gaps_on && ($urandom_range(99) < GapPct);
      end
    end
  end

  // Watchdog: cycles with no word moving on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             StallLimit, pending_cnt);
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    kind        = cdsa_pkg::KindSet;
    word_text   = '0;
    gaps_on     = 1'b1;
    press_go    = 1'b0;
    advance_cnt = 0;
    set_cnt     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, leap rules, rollovers, refused dates
    send_word(cdsa_pkg::KindAdvance, '0);
    send_word(cdsa_pkg::KindSet, "00000228");
    send_word(cdsa_pkg::KindAdvance, noise_text());  // year zero is leap: Feb 29
    send_word(cdsa_pkg::KindAdvance, noise_text());
    send_word(cdsa_pkg::KindSet, "99991231");
    send_word(cdsa_pkg::KindAdvance, '1);            // wraps to year zero
    send_word(cdsa_pkg::KindSet, "19000229");        // century, not leap
    send_word(cdsa_pkg::KindSet, "20000229");        // 400 rule, leap
    send_word(cdsa_pkg::KindSet, "20230229");
    send_word(cdsa_pkg::KindSet, "21000228");
    send_word(cdsa_pkg::KindAdvance, noise_text());
    send_word(cdsa_pkg::KindSet, "20240229");
    send_word(cdsa_pkg::KindSet, "20230431");
    send_word(cdsa_pkg::KindSet, "20230430");
    send_word(cdsa_pkg::KindAdvance, noise_text());
    send_word(cdsa_pkg::KindSet, "20230010");        // month zero
    send_word(cdsa_pkg::KindSet, "20231310");        // month 13
    send_word(cdsa_pkg::KindSet, "20230100");        // day zero
    send_word(cdsa_pkg::KindSet, "20230132");
    send_word(cdsa_pkg::KindSet, "2023/101");        // just below '0'
    send_word(cdsa_pkg::KindSet, "2023:101");        // just above '9'
    send_word(cdsa_pkg::KindSet, '1);
    send_word(cdsa_pkg::KindSet, "00000101");
    send_word(cdsa_pkg::KindSet, "20231231");
    send_word(cdsa_pkg::KindAdvance, noise_text());

    // random part; a quiet stretch holds the long receiver hold-off
    for (int i = 0; i < RandWords; i++) begin
      gaps_on = !(i >= 500 && i < 800);
      if (i == 520) press_go = 1'b1;
      send_random();
    end
    in_valid = 1'b0;
    gaps_on  = 1'b0;

    while (pending_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d words: %0d advances and %0d sets, %0d of them refused.",
             advance_cnt + set_cnt, advance_cnt, set_cnt, refused_cnt);
    $display("%0d results checked, %0d wraps from year 9999, %0d failures.",
             result_cnt, wrap_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
sv/cdsa_pkg.sv
sv/cdsa_front.sv
sv/cdsa_queue.sv
sv/cdsa_back.sv
sv/calendar_date_set_and_advance_top.sv
dv/calendar_date_checker.sv
dv/calendar_date_set_and_advance_top_tb.sv
